[hw/rtl/dnle_pkg.sv]
// shared types and constants for the dotted name to label encoder
`default_nettype none

package dnle_pkg;

    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 6;
    localparam int CELL_IDX_W  = 7;
    localparam int CNT_W       = 7;
    localparam int LABEL_MAX_DEF = 63;

    localparam logic [CHAR_W-1:0] SEP_CHAR = 8'd46;
    localparam logic [CHAR_W-1:0] END_CHAR = 8'd0;

    typedef struct packed {
        logic                  char_wr;
        logic                  term_wr;
        logic                  shift;
        logic [CELL_IDX_W-1:0] widx;
        logic [CHAR_W-1:0]     wdata;
        logic [CHAR_W-1:0]     len_byte;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/dotted_name_to_label_encoder_unit.sv]
// top level of the dotted name to label encoder, chain of byte cells
//
//   channel | role   | signals
//   --------+--------+--------------------------------------------------------------
//   in      | sink   | in_valid in_ready in_char
//   out     | source | out_valid out_ready first_byte second_byte byte_count last label_overflow
//
// an ordinary character is written into cell length+1, or sets overflow when the label is full
// a separator or end is accepted, then the chain drains two bytes
// per output transaction: ceil((length + 1 + end) / 2) transactions
// in_ready is low while the chain drains; out stalls simply hold the chain
// reset clears the length, overflow flag and drain state, cells keep data
`default_nettype none

module dotted_name_to_label_encoder_unit #(
    parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [dnle_pkg::CHAR_W-1:0]   in_char,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [dnle_pkg::CHAR_W-1:0]   first_byte,
    output logic [dnle_pkg::CHAR_W-1:0]   second_byte,
    output logic [1:0]                    byte_count,
    output logic                          last,
    output logic                          label_overflow
);
    import dnle_pkg::*;

    localparam int NUM_CELLS = LABEL_MAX + 2;

    logic [LEN_W-1:0]  len_reg, len_next;
    logic              ovf_reg, ovf_next;
    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;

    logic              in_fire, out_fire, is_term, is_end;
    logic              has_room;
    cell_ctrl_t        ctrl;
    logic [CHAR_W-1:0] cell_data [NUM_CELLS];

    assign in_ready  = !busy_reg;
    assign out_valid = busy_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign is_end    = (in_char == END_CHAR);
    assign is_term   = is_end || (in_char == SEP_CHAR);
    assign has_room  = ({1'b0, len_reg} < CELL_IDX_W'(LABEL_MAX));

    always_comb
    begin
        ctrl.char_wr  = in_fire && !is_term && has_room;
        ctrl.term_wr  = in_fire && is_term;
        ctrl.shift    = out_fire;
        ctrl.widx     = {1'b0, len_reg} + CELL_IDX_W'(1);
        ctrl.wdata    = in_char;
        ctrl.len_byte = {{(CHAR_W-LEN_W){1'b0}}, len_reg};
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_CELLS; gi++)
        begin : g_cell
            logic [CHAR_W-1:0] src;
            if (gi + 2 < NUM_CELLS)
            begin : g_src
                assign src = cell_data[gi+2];
            end
            else
            begin : g_zero
                assign src = '0;
            end
            dnle_cell #(.IDX(gi)) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .shift_in (src),
                .data     (cell_data[gi])
            );
        end
    endgenerate

    always_comb
    begin
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        busy_next = busy_reg;
        rem_next  = rem_reg;
        if (in_fire)
        begin
            if (is_term)
            begin
                busy_next = 1'b1;
                rem_next  = {1'b0, len_reg} + CNT_W'(1) + CNT_W'(is_end);
                len_next  = '0;
            end
            else if (has_room)
            begin
                len_next = len_reg + LEN_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (out_fire)
        begin
            if (rem_reg <= CNT_W'(2))
            begin
                busy_next = 1'b0;
                ovf_next  = 1'b0;
                rem_next  = '0;
            end
            else
            begin
                rem_next = rem_reg - CNT_W'(2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            busy_reg <= 1'b0;
            rem_reg  <= '0;
        end
        else
        begin
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
            busy_reg <= busy_next;
            rem_reg  <= rem_next;
        end
    end

    assign first_byte     = cell_data[0];
    assign second_byte    = (rem_reg >= CNT_W'(2)) ? cell_data[1] : '0;
    assign byte_count     = (rem_reg >= CNT_W'(2)) ? 2'd2 : 2'd1;
    assign last           = (rem_reg <= CNT_W'(2));
    assign label_overflow = ovf_reg;

    a_term_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_char == END_CHAR || in_char == SEP_CHAR) |=> out_valid)
        else $error("terminator did not start output");

    a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !out_valid && in_ready)
        else $error("output continued after last transaction");

    a_single_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count == 2'd2) || last)
        else $error("single byte transaction before last");

    a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> label_overflow == $past(label_overflow))
        else $error("overflow flag changed within a name label");

endmodule

`default_nettype wire

[hw/rtl/dnle_cell.sv]
// one byte cell of the label chain
`default_nettype none

module dnle_cell #(
    parameter int IDX = 0
) (
    input  wire                      clk,
    input  wire dnle_pkg::cell_ctrl_t ctrl,
    input  wire [dnle_pkg::CHAR_W-1:0] shift_in,
    output logic [dnle_pkg::CHAR_W-1:0] data
);
    import dnle_pkg::*;

    logic [CHAR_W-1:0] data_reg;
    logic [CHAR_W-1:0] data_next;
    logic              hit;

    assign hit = (ctrl.char_wr || ctrl.term_wr) && (ctrl.widx == CELL_IDX_W'(IDX));

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = shift_in;
        end
        else if (ctrl.term_wr && (IDX == 0))
        begin
            data_next = ctrl.len_byte;
        end
        else if (hit)
        begin
            data_next = ctrl.term_wr ? END_CHAR : ctrl.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire
